@@ rtl/fhbd_pkg.sv @@
// Shared types and constants for the font hint bytecode decoder.
// No dependencies; fhbd_front, fhbd_back and the top level import this package.
package fhbd_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int STACK_DEPTH_DEF   = 256;
	localparam int FUNC_COUNT_DEF    = 64;
	localparam int PROGRAM_BYTES_DEF = 65536;

	// Stack address field in the queue word, wide enough for the largest stack
	localparam int SP_ADDR_W = 12;

	// Queue depths between the parts
	localparam int MIDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 2;

	// Opcodes
	localparam logic [7:0] OP_SPVTCA_Y = 8'h02;
	localparam logic [7:0] OP_SPVTCA_X = 8'h03;
	localparam logic [7:0] OP_FDEF     = 8'h2C;
	localparam logic [7:0] OP_ENDF     = 8'h2D;
	localparam logic [7:0] OP_NPUSHB   = 8'h40;
	localparam logic [7:0] OP_NPUSHW   = 8'h41;
	localparam logic [4:0] OP_PUSHB_HI = 5'b10110;
	localparam logic [4:0] OP_PUSHW_HI = 5'b10111;

	localparam logic [15:0] UNIT_2_14 = 16'h4000;

	typedef enum logic [1:0] {
		KIND_PUSH  = 2'd0,
		KIND_FUNC  = 2'd1,
		KIND_PROJ  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_UNKNOWN   = 3'd0,
		ERR_OVERFLOW  = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_BAD_ID    = 3'd3,
		ERR_TRUNC     = 3'd4
	} err_t;

	// Parser modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_COUNT   = 3'd1,
		M_BYTES   = 3'd2,
		M_WORD_HI = 3'd3,
		M_WORD_LO = 3'd4,
		M_BODY    = 3'd5
	} mode_t;

	// What the back part does with a queued word
	typedef enum logic [1:0] {
		BOP_RESULT = 2'd0,
		BOP_FDEF   = 2'd1,
		BOP_ENDF   = 2'd2
	} bop_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		kind_t              kind;
		err_t               error_code;
		logic signed [15:0] pushed_value;
		logic [5:0]         function_id;
		logic [15:0]        function_start;
		logic [15:0]        function_length;
		logic signed [15:0] proj_x;
		logic signed [15:0] proj_y;
		logic [8:0]         stack_depth;
		logic               program_end;
	} result_t;

	typedef struct packed {
		bop_t                 op;
		logic                 wr;
		logic [SP_ADDR_W-1:0] addr;
		logic [15:0]          data;
		result_t              res;
	} mid_t;

endpackage

@@ rtl/fhbd_fifo.sv @@
// Small synchronous queue with full/empty flags, any packed word type.
// Depends on nothing but its type parameter.
module fhbd_fifo #(
	parameter type entry_t = logic,
	parameter int  DEPTH   = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  entry_t wdata,
	input  logic   pop,
	output logic   empty,
	output entry_t rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/fhbd_front.sv @@
// Front part: takes program bytes, runs the parser and stack pointer,
// and hands one word per result-bearing byte to the back part. Uses fhbd_pkg.
module fhbd_front #(
	parameter int STACK_DEPTH   = fhbd_pkg::STACK_DEPTH_DEF,
	parameter int PROGRAM_BYTES = fhbd_pkg::PROGRAM_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  fhbd_pkg::item_t item,
	output logic            enq,
	output fhbd_pkg::mid_t  enq_word
);
	import fhbd_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	mode_t             mode_q, mode_nx;
	logic [8:0]        rem_q, rem_d, rem_dec;
	logic [7:0]        hi_q, hi_d;
	logic              word_q, word_d;
	logic [SP_W-1:0]   sp_q, sp_d;
	logic [15:0]       off_q, off_nx;
	logic [16:0]       off_inc;
	logic [15:0]       bstart_q, bstart_d, blen_q, blen_d;
	logic              fdef_ok_q, fdef_ok_d;
	logic [15:0]       projx_q, projx_d, projy_q, projy_d;
	logic [7:0]        b;
	logic              last;
	logic              do_push, send_fdef, send_endf, have, wr;
	logic [15:0]       pv, val;
	kind_t             kind;
	err_t              err;

	assign b    = item.code_byte;
	assign last = item.last_byte;

	// operand count after one operand is consumed
	assign rem_dec = (rem_q != '0) ? rem_q - 9'd1 : '0;

	// offset of the next byte, wrapping at the program size
	assign off_inc = {1'b0, off_q} + 17'd1;
	assign off_nx  = (off_inc >= 17'(PROGRAM_BYTES)) ? '0 : off_inc[15:0];

	// next parser mode, before the end-of-program return to idle
	always_comb begin
		mode_nx = mode_q;
		unique case (mode_q)
			M_IDLE: begin
				if (b == OP_NPUSHB || b == OP_NPUSHW) begin
					mode_nx = M_COUNT;
				end else if (b[7:3] == OP_PUSHB_HI) begin
					mode_nx = M_BYTES;
				end else if (b[7:3] == OP_PUSHW_HI) begin
					mode_nx = M_WORD_HI;
				end else if (b == OP_FDEF) begin
					mode_nx = M_BODY;
				end
			end
			M_COUNT: begin
				mode_nx = (b == 8'd0) ? M_IDLE : (word_q ? M_WORD_HI : M_BYTES);
			end
			M_WORD_HI: begin
				mode_nx = M_WORD_LO;
			end
			M_BYTES, M_WORD_LO: begin
				mode_nx = (rem_dec == '0) ? M_IDLE : (word_q ? M_WORD_HI : M_BYTES);
			end
			M_BODY: begin
				if (b == OP_ENDF) begin
					mode_nx = M_IDLE;
				end
			end
			default: begin
				mode_nx = M_IDLE;
			end
		endcase
	end

	// datapath and result of this byte
	always_comb begin
		rem_d     = rem_q;
		hi_d      = hi_q;
		word_d    = word_q;
		sp_d      = sp_q;
		bstart_d  = bstart_q;
		blen_d    = blen_q;
		fdef_ok_d = fdef_ok_q;
		projx_d   = projx_q;
		projy_d   = projy_q;
		do_push   = 1'b0;
		pv        = '0;
		send_fdef = 1'b0;
		send_endf = 1'b0;
		have      = 1'b0;
		wr        = 1'b0;
		val       = '0;
		kind      = KIND_PUSH;
		err       = ERR_UNKNOWN;

		unique case (mode_q)
			M_IDLE: begin
				if (b == OP_NPUSHB || b == OP_NPUSHW) begin
					word_d = (b == OP_NPUSHW);
				end else if (b[7:3] == OP_PUSHB_HI) begin
					word_d = 1'b0;
					rem_d  = 9'(b[2:0]) + 9'd1;
				end else if (b[7:3] == OP_PUSHW_HI) begin
					word_d = 1'b1;
					rem_d  = 9'(b[2:0]) + 9'd1;
				end else if (b == OP_SPVTCA_Y || b == OP_SPVTCA_X) begin
					projx_d = b[0] ? UNIT_2_14 : '0;
					projy_d = b[0] ? '0 : UNIT_2_14;
					have    = 1'b1;
					kind    = KIND_PROJ;
				end else if (b == OP_FDEF) begin
					bstart_d  = off_nx;
					blen_d    = '0;
					fdef_ok_d = (sp_q != '0);
					if (sp_q == '0) begin
						have = 1'b1;
						kind = KIND_ERROR;
						err  = ERR_UNDERFLOW;
					end else begin
						sp_d      = sp_q - 1'b1;
						send_fdef = 1'b1;
					end
				end else begin
					have = 1'b1;
					kind = KIND_ERROR;
					err  = ERR_UNKNOWN;
				end
			end
			M_COUNT: begin
				rem_d = 9'(b);
			end
			M_BYTES: begin
				do_push = 1'b1;
				pv      = {8'd0, b};
			end
			M_WORD_HI: begin
				hi_d = b;
			end
			M_WORD_LO: begin
				do_push = 1'b1;
				pv      = {hi_q, b};
			end
			M_BODY: begin
				if (b == OP_ENDF) begin
					send_endf = fdef_ok_q;
				end else if (blen_q != 16'hFFFF) begin
					blen_d = blen_q + 16'd1;
				end
			end
			default: begin
			end
		endcase

		// operand push, dropped when the stack is full
		if (do_push) begin
			rem_d = rem_dec;
			have  = 1'b1;
			if (sp_q != SP_W'(STACK_DEPTH)) begin
				wr   = 1'b1;
				sp_d = sp_q + 1'b1;
				kind = KIND_PUSH;
				val  = pv;
			end else begin
				kind = KIND_ERROR;
				err  = ERR_OVERFLOW;
			end
		end

		// program ends inside an instruction; a pending FDEF is settled in the back
		if (last) begin
			if (mode_nx != M_IDLE && !(have && kind == KIND_ERROR) && !send_fdef) begin
				have = 1'b1;
				kind = KIND_ERROR;
				err  = ERR_TRUNC;
				val  = '0;
			end
			rem_d  = '0;
			word_d = 1'b0;
		end
	end

	// word for the back part
	always_comb begin
		enq_word     = '0;
		enq_word.op  = send_fdef ? BOP_FDEF : (send_endf ? BOP_ENDF : BOP_RESULT);
		enq_word.wr  = wr;
		enq_word.addr = send_fdef ? SP_ADDR_W'(sp_q - 1'b1) : SP_ADDR_W'(sp_q);
		enq_word.data = pv;
		enq_word.res.kind            = send_endf ? KIND_FUNC :
		                               (send_fdef ? KIND_ERROR : kind);
		enq_word.res.error_code      = err;
		enq_word.res.pushed_value    = val;
		enq_word.res.function_start  = send_endf ? bstart_q : '0;
		enq_word.res.function_length = send_endf ? blen_q : '0;
		enq_word.res.proj_x          = projx_d;
		enq_word.res.proj_y          = projy_d;
		enq_word.res.stack_depth     = 9'(sp_d);
		enq_word.res.program_end     = last;
	end

	assign enq = accept && (have || send_fdef || send_endf);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			rem_q     <= '0;
			hi_q      <= '0;
			word_q    <= 1'b0;
			sp_q      <= '0;
			off_q     <= '0;
			bstart_q  <= '0;
			blen_q    <= '0;
			fdef_ok_q <= 1'b0;
			projx_q   <= UNIT_2_14;
			projy_q   <= '0;
		end else if (accept) begin
			mode_q    <= last ? M_IDLE : mode_nx;
			rem_q     <= rem_d;
			hi_q      <= hi_d;
			word_q    <= word_d;
			sp_q      <= sp_d;
			off_q     <= last ? '0 : off_nx;
			bstart_q  <= bstart_d;
			blen_q    <= blen_d;
			fdef_ok_q <= fdef_ok_d;
			projx_q   <= projx_d;
			projy_q   <= projy_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> mode_q == M_IDLE && off_q == '0 && rem_q == '0)
		else $error("parser not back to idle after last byte");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q == M_BODY && !last && b != OP_ENDF
		|=> (blen_q == $past(blen_q) + 16'd1) || ($past(blen_q) == 16'hFFFF))
		else $error("body length did not advance");
`endif

endmodule

@@ rtl/fhbd_back.sv @@
// Back part: owns the operand stack memory, settles FDEF ids and ENDF
// results, and feeds the result queue. Uses fhbd_pkg.
module fhbd_back #(
	parameter int STACK_DEPTH = fhbd_pkg::STACK_DEPTH_DEF,
	parameter int FUNC_COUNT  = fhbd_pkg::FUNC_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	input  fhbd_pkg::mid_t    mid_word,
	output logic              mid_pop,
	input  logic              out_full,
	output logic              out_push,
	output fhbd_pkg::result_t out_word
);
	import fhbd_pkg::*;

	localparam int SP_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [15:0]      stack_mem [STACK_DEPTH];
	logic [SP_AW-1:0] addr;
	logic             valid_s1;
	mid_t             ent_s1;
	logic [15:0]      rdata_s1;
	logic             pend_q;
	logic [5:0]       pend_id_q;
	logic             bad_id, has_res, s1_leave;

	assign addr   = mid_word.addr[SP_AW-1:0];
	assign bad_id = ({1'b0, rdata_s1} >= 17'(FUNC_COUNT));

	// result of the word in stage 1
	always_comb begin
		out_word = ent_s1.res;
		has_res  = 1'b0;
		unique case (ent_s1.op)
			BOP_RESULT: begin
				has_res = 1'b1;
			end
			BOP_FDEF: begin
				if (bad_id) begin
					has_res             = 1'b1;
					out_word.error_code = ERR_BAD_ID;
				end else if (ent_s1.res.program_end) begin
					has_res             = 1'b1;
					out_word.error_code = ERR_TRUNC;
				end
			end
			BOP_ENDF: begin
				has_res              = pend_q;
				out_word.function_id = pend_id_q;
			end
			default: begin
			end
		endcase
	end

	assign s1_leave = valid_s1 && (!has_res || !out_full);
	assign out_push = valid_s1 && has_res && !out_full;
	assign mid_pop  = !mid_empty && (!valid_s1 || s1_leave);

	// stack memory: write for pushes, registered read for FDEF
	always_ff @(posedge clk) begin
		if (mid_pop && mid_word.wr) begin
			stack_mem[addr] <= mid_word.data;
		end
		if (mid_pop) begin
			rdata_s1 <= stack_mem[addr];
			ent_s1   <= mid_word;
		end
	end

	// stage valid and pending function
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pend_q    <= 1'b0;
			pend_id_q <= '0;
		end else begin
			if (mid_pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_leave) begin
				valid_s1 <= 1'b0;
			end
			if (s1_leave && ent_s1.op == BOP_FDEF) begin
				pend_q    <= !bad_id && !ent_s1.res.program_end;
				pend_id_q <= rdata_s1[5:0];
			end else if (s1_leave && ent_s1.op == BOP_ENDF) begin
				pend_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// read data of non-FDEF words may come from unwritten entries, so only the word is held
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_leave |=> valid_s1 && $stable(ent_s1))
		else $error("stalled stage 1 word lost");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result pushed into a full queue");

	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("word popped from an empty queue");
`endif

endmodule

@@ rtl/font_hint_bytecode_decoder_core.sv @@
// Font hint bytecode decoder, top level: front parser, word queue, back
// part with the operand stack, and the result queue. Uses fhbd_pkg.
//
// Takes one program byte per cycle while full is low, with no reset sweep:
// the front parser decides mode, stack pointer and projection for each
// byte combinationally, and the back part reads or writes the operand
// stack memory at one word per cycle unless the result queue is full. A
// result passes the four-word queue, the registered stack read stage and
// the two-word result queue before it shows on the result port.
// full rises only when the word queue fills because results are not being
// popped. FDEF looks up its id with a registered stack read in the same
// back stage that every word passes, so its outcome comes with no extra
// latency and in program order.
module font_hint_bytecode_decoder_core #(
	parameter int STACK_DEPTH   = fhbd_pkg::STACK_DEPTH_DEF,
	parameter int FUNC_COUNT    = fhbd_pkg::FUNC_COUNT_DEF,
	parameter int PROGRAM_BYTES = fhbd_pkg::PROGRAM_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  fhbd_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output fhbd_pkg::result_t result
);
	import fhbd_pkg::*;

	logic    accept, enq, mid_empty, mid_pop, out_full, out_push;
	mid_t    enq_word, mid_word;
	result_t out_word;

	assign accept = push && !full;

	fhbd_front #(
		.STACK_DEPTH  (STACK_DEPTH),
		.PROGRAM_BYTES(PROGRAM_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.enq     (enq),
		.enq_word(enq_word)
	);

	fhbd_fifo #(
		.entry_t(mid_t),
		.DEPTH  (MIDQ_DEPTH)
	) u_midq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (enq),
		.full  (full),
		.wdata (enq_word),
		.pop   (mid_pop),
		.empty (mid_empty),
		.rdata (mid_word)
	);

	fhbd_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.FUNC_COUNT (FUNC_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_word (mid_word),
		.mid_pop  (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_word (out_word)
	);

	fhbd_fifo #(
		.entry_t(result_t),
		.DEPTH  (OUTQ_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.wdata (out_word),
		.pop   (pop),
		.empty (empty),
		.rdata (result)
	);

endmodule

@@ test/tb_font_hint_bytecode_decoder_core.sv @@
// Self-checking testbench for font_hint_bytecode_decoder_core: streams hint programs one byte
// per word and checks every result word against an in-bench decoder model. Needs fhbd_pkg and
// the rtl/ sources only.
`timescale 1ns / 100ps

module tb_font_hint_bytecode_decoder_core;
	import fhbd_pkg::*;

	localparam int STACK_DEPTH   = STACK_DEPTH_DEF;
	localparam int FUNC_COUNT    = FUNC_COUNT_DEF;
	localparam int PROGRAM_BYTES = PROGRAM_BYTES_DEF;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_CYCLES  = 10;

	// Decoder model plus the queue of result words it predicts
	class hint_decode_scoreboard;
		mode_t       mode;
		logic [8:0]  remaining;
		logic [7:0]  hi_byte;
		logic        word_mode;
		logic [15:0] stack_mem [STACK_DEPTH];
		int          sp;
		int          offset;
		logic [5:0]  fn_id;
		logic        fn_valid;
		logic [15:0] fn_start;
		logic [15:0] fn_len;
		logic [15:0] px;
		logic [15:0] py;
		result_t     cur;
		bit          cur_hit;
		result_t     expected_words [$];
		int          bytes_seen;
		int          words_checked;
		int          error_words;
		int          mismatches;

		function new();
			mode      = M_IDLE;
			remaining = '0;
			hi_byte   = '0;
			word_mode = 1'b0;
			sp        = 0;
			offset    = 0;
			fn_id     = '0;
			fn_valid  = 1'b0;
			fn_start  = '0;
			fn_len    = '0;
			px        = UNIT_2_14;
			py        = '0;
		endfunction

		function int next_off(int o);
			return (o + 1 >= PROGRAM_BYTES) ? 0 : o + 1;
		endfunction

		function void flag(err_t code);
			cur_hit        = 1'b1;
			cur.kind       = KIND_ERROR;
			cur.error_code = code;
		endfunction

		// a full stack drops the value
		function void push_value(logic [15:0] v);
			if (sp < STACK_DEPTH) begin
				stack_mem[sp] = v;
				sp++;
				cur_hit          = 1'b1;
				cur.kind         = KIND_PUSH;
				cur.pushed_value = v;
			end else begin
				flag(ERR_OVERFLOW);
			end
		endfunction

		function void next_operand();
			if (remaining != 0)
				remaining--;
			if (remaining == 0)
				mode = M_IDLE;
			else if (word_mode)
				mode = M_WORD_HI;
			else
				mode = M_BYTES;
		endfunction

		function void decode_op(logic [7:0] b);
			logic [15:0] id;
			if (b == OP_NPUSHB || b == OP_NPUSHW) begin
				word_mode = (b == OP_NPUSHW);
				mode      = M_COUNT;
			end else if (b[7:3] == OP_PUSHB_HI) begin
				word_mode = 1'b0;
				remaining = {6'd0, b[2:0]} + 9'd1;
				mode      = M_BYTES;
			end else if (b[7:3] == OP_PUSHW_HI) begin
				word_mode = 1'b1;
				remaining = {6'd0, b[2:0]} + 9'd1;
				mode      = M_WORD_HI;
			end else if (b == OP_SPVTCA_Y || b == OP_SPVTCA_X) begin
				// dual vector follows, nothing else to track
				if (b[0]) begin
					px = UNIT_2_14;
					py = '0;
				end else begin
					px = '0;
					py = UNIT_2_14;
				end
				cur_hit  = 1'b1;
				cur.kind = KIND_PROJ;
			end else if (b == OP_FDEF) begin
				fn_valid = 1'b0;
				fn_id    = '0;
				if (sp == 0) begin
					flag(ERR_UNDERFLOW);
				end else begin
					sp--;
					id = stack_mem[sp];
					if (id >= FUNC_COUNT) begin
						flag(ERR_BAD_ID);
					end else begin
						fn_id    = id[5:0];
						fn_valid = 1'b1;
					end
				end
				fn_start = next_off(offset);
				fn_len   = '0;
				mode     = M_BODY;
			end else begin
				flag(ERR_UNKNOWN);
			end
		endfunction

		// one accepted input word
		function void note_byte(item_t it);
			logic [7:0] b;
			b       = it.code_byte;
			cur     = '0;
			cur_hit = 1'b0;
			case (mode)
			M_IDLE: decode_op(b);
			M_COUNT: begin
				remaining = {1'b0, b};
				if (b == 8'd0)
					mode = M_IDLE;
				else if (word_mode)
					mode = M_WORD_HI;
				else
					mode = M_BYTES;
			end
			M_BYTES: begin
				push_value({8'h00, b});
				next_operand();
			end
			M_WORD_HI: begin
				hi_byte = b;
				mode    = M_WORD_LO;
			end
			M_WORD_LO: begin
				push_value({hi_byte, b});
				next_operand();
			end
			M_BODY: begin
				if (b == OP_ENDF) begin
					if (fn_valid) begin
						cur_hit             = 1'b1;
						cur.kind            = KIND_FUNC;
						cur.function_id     = fn_id;
						cur.function_start  = fn_start;
						cur.function_length = fn_len;
					end
					fn_valid = 1'b0;
					mode     = M_IDLE;
				end else if (fn_len != 16'hFFFF) begin
					fn_len++;
				end
			end
			default: mode = M_IDLE;
			endcase

			// end of program: a dangling instruction is truncated unless already an error
			if (it.last_byte) begin
				if (mode != M_IDLE && !(cur_hit && cur.kind == KIND_ERROR)) begin
					cur            = '0;
					cur_hit        = 1'b1;
					cur.kind       = KIND_ERROR;
					cur.error_code = ERR_TRUNC;
				end
				mode      = M_IDLE;
				remaining = '0;
				word_mode = 1'b0;
				fn_valid  = 1'b0;
				offset    = 0;
			end else begin
				offset = next_off(offset);
			end

			bytes_seen++;
			if (cur_hit) begin
				cur.proj_x      = px;
				cur.proj_y      = py;
				cur.stack_depth = sp[8:0];
				cur.program_end = it.last_byte;
				expected_words.push_back(cur);
			end
		endfunction

		function string show(result_t w);
			return $sformatf({"kind=%0d err=%0d value=%0d id=%0d start=%0d len=%0d",
				" proj=(%0d,%0d) depth=%0d end=%0b"}, w.kind, w.error_code, w.pushed_value,
				w.function_id, w.function_start, w.function_length, w.proj_x, w.proj_y,
				w.stack_depth, w.program_end);
		endfunction

		// one accepted result word against the oldest prediction
		function void check_word(result_t got);
			result_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result word with none expected: %s", show(got));
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (want.kind == KIND_ERROR)
				error_words++;
			if (got.kind !== want.kind || got.error_code !== want.error_code ||
					got.pushed_value !== want.pushed_value ||
					got.function_id !== want.function_id ||
					got.function_start !== want.function_start ||
					got.function_length !== want.function_length ||
					got.proj_x !== want.proj_x || got.proj_y !== want.proj_y ||
					got.stack_depth !== want.stack_depth ||
					got.program_end !== want.program_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result word %0d\n  expected %s\n  actual   %s",
						words_checked, show(want), show(got));
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	hint_decode_scoreboard sb;

	font_hint_bytecode_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	// cycle guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d result words outstanding", cycles,
				sb.expected_words.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: check accepted words, random pop stalls
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(result);
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one program byte, with random gaps ahead of it; push stays high after acceptance
	task automatic send(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push           <= 1'b1;
		item.code_byte <= b;
		item.last_byte <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_byte('{code_byte: b, last_byte: lst});
	endtask

	function automatic logic [7:0] operand_byte();
		if ($urandom_range(7) != 0)
			return 8'($urandom_range(255));
		case ($urandom_range(3))
		0: return 8'h00;
		1: return 8'h7F;
		2: return 8'h80;
		default: return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == OP_ENDF);
		return b;
	endfunction

	// short hand-picked program covering each opcode and corner
	task automatic directed_cases();
		send(OP_FDEF, 1'b0);                 // empty stack
		send(OP_ENDF, 1'b0);                 // nothing stored
		send({OP_PUSHW_HI, 3'd1}, 1'b0);
		send(8'h7F, 1'b0);
		send(8'hFF, 1'b0);                   // +32767
		send(8'h80, 1'b0);
		send(8'h00, 1'b0);                   // -32768
		send(OP_FDEF, 1'b0);                 // negative id
		send(OP_ENDF, 1'b0);
		send({OP_PUSHB_HI, 3'd1}, 1'b0);
		send(8'h40, 1'b0);                   // id 64
		send(8'h3F, 1'b0);                   // id 63
		send(OP_FDEF, 1'b0);
		send(OP_ENDF, 1'b0);                 // empty body
		send(OP_FDEF, 1'b0);                 // id 64 out of range
		send(8'hFF, 1'b0);
		send(OP_ENDF, 1'b0);
		send(OP_NPUSHB, 1'b0);
		send(8'h00, 1'b0);                   // zero count
		send(OP_NPUSHW, 1'b0);
		send(8'h00, 1'b0);
		send(OP_SPVTCA_Y, 1'b0);
		send(OP_SPVTCA_X, 1'b0);
		send(8'hFF, 1'b0);                   // unknown opcode
		send(OP_FDEF, 1'b1);                 // bad id wins over truncation
		send({OP_PUSHB_HI, 3'd7}, 1'b0);
		send(8'h00, 1'b1);                   // truncated push
		send({OP_PUSHB_HI, 3'd0}, 1'b0);
		send(8'hFF, 1'b1);                   // clean end of program
	endtask

	// one random instruction, mostly well formed, sometimes noise or cut short
	task automatic random_instr();
		logic [7:0] seq [$];
		logic [2:0] cnt;
		int         pick;
		int         n;
		int         cut;
		int         end_pick;
		logic [7:0] b;
		bit         close;
		pick = $urandom_range(99);
		cnt  = 3'($urandom_range(7));
		if (pick < 24) begin
			seq.push_back({OP_PUSHB_HI, cnt});
			repeat (cnt + 1)
				seq.push_back(operand_byte());
		end else if (pick < 38) begin
			seq.push_back({OP_PUSHW_HI, cnt});
			repeat (2 * (cnt + 1))
				seq.push_back(operand_byte());
		end else if (pick < 46) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
			seq.push_back(OP_NPUSHB);
			seq.push_back(8'(n));
			repeat (n)
				seq.push_back(operand_byte());
		end else if (pick < 52) begin
			n = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(4);
			seq.push_back(OP_NPUSHW);
			seq.push_back(8'(n));
			repeat (2 * n)
				seq.push_back(operand_byte());
		end else if (pick < 60) begin
			seq.push_back($urandom_range(1) ? OP_SPVTCA_X : OP_SPVTCA_Y);
		end else if (pick < 85) begin
			// function definition, with an id pushed just ahead unless bare
			n = $urandom_range(9);
			if (pick >= 80) begin
			end else if (n < 7) begin
				seq.push_back({OP_PUSHB_HI, 3'd0});
				seq.push_back(8'($urandom_range(FUNC_COUNT - 1)));
			end else if (n < 9) begin
				seq.push_back({OP_PUSHB_HI, 3'd0});
				seq.push_back(8'($urandom_range(255, FUNC_COUNT)));
			end else begin
				seq.push_back({OP_PUSHW_HI, 3'd0});
				seq.push_back(operand_byte());
				seq.push_back(operand_byte());
			end
			seq.push_back(OP_FDEF);
			n = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(5);
			repeat (n)
				seq.push_back(body_byte());
			seq.push_back(OP_ENDF);
		end else begin
			// noise, mostly bytes that are no opcode
			b = 8'($urandom_range(255));
			if ($urandom_range(9) != 0)
				while (b == OP_NPUSHB || b == OP_NPUSHW || b[7:4] == 4'hB ||
						b == OP_SPVTCA_Y || b == OP_SPVTCA_X || b == OP_FDEF)
					b = 8'($urandom_range(255));
			seq.push_back(b);
		end

		end_pick = $urandom_range(15);
		if (end_pick == 0 && seq.size() > 1) begin
			cut = $urandom_range(seq.size() - 1, 1);
			while (seq.size() > cut)
				void'(seq.pop_back());
			close = 1'b1;
		end else begin
			close = (end_pick <= 2);
		end
		foreach (seq[i])
			send(seq[i], close && (i == seq.size() - 1));
	endtask

	task automatic random_phase(input int n_bytes);
		int first;
		first = sb.bytes_seen;
		while (sb.bytes_seen - first < n_bytes)
			random_instr();
	endtask

	// main sequence
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 29;
		recv_idle_pct = 85;
		directed_cases();
		random_phase(380);

		send_idle_pct = 85;
		recv_idle_pct = 29;
		random_phase(380);

		// no idling; fill the stack to force overflow, then random again
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send(OP_NPUSHB, 1'b0);
		send(8'hFF, 1'b0);
		repeat (255)
			send(operand_byte(), 1'b0);
		send({OP_PUSHB_HI, 3'd1}, 1'b0);
		send(operand_byte(), 1'b0);
		send(operand_byte(), 1'b0);
		random_phase(130);
		push <= 1'b0;

		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d program bytes sent, %0d result words checked (%0d error words).",
			sb.bytes_seen, sb.words_checked, sb.error_words);
		$display("Pushes, FDEF/ENDF, SPVTCA, errors, stack overflow, 3 idle mixes; %0d mismatches.",
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
